// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define CCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ccs assertion failed");

// Property checked on every edge, reset included.
`define CCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ccs assertion failed");

`endif

// ===== hdl/ccs_pkg.sv =====
// Types and codes of the charger control sequencer.
`timescale 1ns / 1ps
package ccs_pkg;

  localparam int StateW = 4;
  localparam int CmdW   = 3;

  // sequencer states
  localparam logic [StateW-1:0] ST_ERROR       = 4'd0;
  localparam logic [StateW-1:0] ST_CLEAR_ERROR = 4'd1;
  localparam logic [StateW-1:0] ST_CLEAR_HVC   = 4'd2;
  localparam logic [StateW-1:0] ST_IDLE_HVC    = 4'd3;
  localparam logic [StateW-1:0] ST_STANDBY     = 4'd4;
  localparam logic [StateW-1:0] ST_CHARGE_REQ  = 4'd5;
  localparam logic [StateW-1:0] ST_CHARGE      = 4'd6;
  localparam logic [StateW-1:0] ST_SLOW_CHARGE = 4'd7;
  localparam logic [StateW-1:0] ST_SHUTDOWN    = 4'd8;

  // opcodes
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // local requests
  localparam logic [CmdW-1:0] REQ_NONE  = 3'd0;
  localparam logic [CmdW-1:0] REQ_RESET = 3'd1;
  localparam logic [CmdW-1:0] REQ_SLOW  = 3'd2;
  localparam logic [CmdW-1:0] REQ_FAST  = 3'd3;
  localparam logic [CmdW-1:0] REQ_OFF   = 3'd4;

  // pack states
  localparam logic [2:0] PK_ERROR       = 3'd1;
  localparam logic [2:0] PK_CLEAR_ERROR = 3'd2;
  localparam logic [2:0] PK_STANDBY     = 3'd3;
  localparam logic [2:0] PK_TRICKLE     = 3'd4;
  localparam logic [2:0] PK_CONST_V     = 3'd5;
  localparam logic [2:0] PK_DISCHARGE   = 3'd6;

  // pack modes
  localparam logic [1:0] PM_ERROR  = 2'd0;
  localparam logic [1:0] PM_IDLE   = 2'd1;
  localparam logic [1:0] PM_CHARGE = 2'd2;

  // link commands
  localparam logic [1:0] LK_RESET = 2'd1;
  localparam logic [1:0] LK_RUN   = 2'd2;
  localparam logic [1:0] LK_IDLE  = 2'd3;

  typedef struct packed {
    logic            opcode;
    logic [CmdW-1:0] command;
    logic [2:0]      hvc_state;
    logic [1:0]      hvc_mode;
    logic [1:0]      link_command;
    logic [15:0]     charger_one_current;
    logic [15:0]     charger_two_current;
  } in_item_t;

  typedef struct packed {
    logic [StateW-1:0] current_state;
    logic [1:0]        hvc_mode_request;
    logic              charge_enable;
  } out_item_t;

  typedef struct packed {
    logic [StateW-1:0] mode_state;
    logic [CmdW-1:0]   pending_command;
  } seq_state_t;

endpackage

// ===== hdl/ccs_step.sv =====
// Next-state and result decode for one sequencer transaction.
`timescale 1ns / 1ps
module ccs_step (
  input  ccs_pkg::in_item_t   item,
  input  ccs_pkg::seq_state_t cur,
  output ccs_pkg::seq_state_t nxt,
  output ccs_pkg::out_item_t  result
);

  logic [ccs_pkg::StateW-1:0] tick_state;
  logic                       pk_err;
  logic [ccs_pkg::CmdW-1:0]   req;

  assign pk_err = (item.hvc_state == ccs_pkg::PK_ERROR);
  assign req    = cur.pending_command;

  always_comb begin
    tick_state = cur.mode_state;
    case (cur.mode_state)
      ccs_pkg::ST_ERROR: begin
        if (req == ccs_pkg::REQ_RESET || item.link_command == ccs_pkg::LK_RESET)
          tick_state = ccs_pkg::ST_CLEAR_ERROR;
      end
      ccs_pkg::ST_CLEAR_ERROR: tick_state = ccs_pkg::ST_CLEAR_HVC;
      ccs_pkg::ST_CLEAR_HVC: begin
        if (item.hvc_state == ccs_pkg::PK_CLEAR_ERROR) tick_state = ccs_pkg::ST_IDLE_HVC;
      end
      ccs_pkg::ST_IDLE_HVC: begin
        if (pk_err) tick_state = ccs_pkg::ST_ERROR;
        else if (item.hvc_mode == ccs_pkg::PM_IDLE && item.hvc_state == ccs_pkg::PK_STANDBY)
          tick_state = ccs_pkg::ST_STANDBY;
      end
      ccs_pkg::ST_STANDBY: begin
        if (pk_err) tick_state = ccs_pkg::ST_ERROR;
        else if (req inside {ccs_pkg::REQ_SLOW, ccs_pkg::REQ_FAST} ||
                 item.link_command == ccs_pkg::LK_RUN)
          tick_state = ccs_pkg::ST_CHARGE_REQ;
      end
      ccs_pkg::ST_CHARGE_REQ: begin
        if (pk_err) tick_state = ccs_pkg::ST_ERROR;
        else if (item.hvc_state == ccs_pkg::PK_TRICKLE) tick_state = ccs_pkg::ST_CHARGE;
      end
      ccs_pkg::ST_CHARGE: begin
        if (pk_err) tick_state = ccs_pkg::ST_ERROR;
        else if (req == ccs_pkg::REQ_OFF || item.link_command == ccs_pkg::LK_IDLE)
          tick_state = ccs_pkg::ST_SHUTDOWN;
        else if (item.hvc_state == ccs_pkg::PK_CONST_V) tick_state = ccs_pkg::ST_SLOW_CHARGE;
      end
      ccs_pkg::ST_SLOW_CHARGE: begin
        if (pk_err) tick_state = ccs_pkg::ST_ERROR;
        else if (item.hvc_state inside {ccs_pkg::PK_DISCHARGE, ccs_pkg::PK_STANDBY} ||
                 req == ccs_pkg::REQ_OFF || item.link_command == ccs_pkg::LK_IDLE)
          tick_state = ccs_pkg::ST_STANDBY;
      end
      ccs_pkg::ST_SHUTDOWN: begin
        if (pk_err) tick_state = ccs_pkg::ST_ERROR;
        else if (item.charger_one_current == 16'd0 && item.charger_two_current == 16'd0)
          tick_state = ccs_pkg::ST_STANDBY;
      end
      default: tick_state = ccs_pkg::ST_ERROR;
    endcase
  end

  always_comb begin
    nxt = cur;
    if (item.opcode == ccs_pkg::OP_TICK) begin
      nxt.mode_state      = tick_state;
      nxt.pending_command = ccs_pkg::REQ_NONE;
    end else if (!(item.command == ccs_pkg::REQ_RESET &&
                   cur.mode_state != ccs_pkg::ST_ERROR)) begin
      nxt.pending_command = item.command;
    end
  end

  always_comb begin
    result.current_state = nxt.mode_state;
    result.charge_enable = (nxt.mode_state != ccs_pkg::ST_ERROR);
    case (nxt.mode_state)
      ccs_pkg::ST_CLEAR_HVC: result.hvc_mode_request = ccs_pkg::PM_ERROR;
      ccs_pkg::ST_CHARGE_REQ, ccs_pkg::ST_CHARGE, ccs_pkg::ST_SHUTDOWN:
        result.hvc_mode_request = ccs_pkg::PM_CHARGE;
      default: result.hvc_mode_request = ccs_pkg::PM_IDLE;
    endcase
  end

endmodule

// ===== hdl/charger_control_sequencer_core.sv =====
// Charger control sequencer: input register, step decode, result register.
// Takes one transaction per cycle while in_stall is low. Each transaction
// is captured in an input register and decoded against the sequencer state
// in one pass. The result register loads when out_data is empty or taken, so
// the result passes the input and result registers before it shows on out_data.
// The state (sequencer state and pending local request) updates as the
// transaction moves into the result register. in_stall rises only when a
// transaction waits in the input register behind a stalled result.
`timescale 1ns / 1ps
module charger_control_sequencer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ccs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ccs_pkg::out_item_t  out_data
);

  logic                 in_full;
  ccs_pkg::in_item_t    in_item;
  ccs_pkg::seq_state_t  seq;
  ccs_pkg::seq_state_t  seq_next;
  ccs_pkg::out_item_t   result;
  logic                 advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  ccs_step u_step (
    .item   (in_item),
    .cur    (seq),
    .nxt    (seq_next),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq.mode_state      <= ccs_pkg::ST_CLEAR_ERROR;
      seq.pending_command <= ccs_pkg::REQ_NONE;
      out_valid           <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
      if (in_full) begin
        seq <= seq_next;
      end
    end
    if (advance && in_full) begin
      out_data <= result;
    end
  end

endmodule

// ===== hdl/ccs_checker.sv =====
// Port-level assertions for the charger control sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ccs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input ccs_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ccs_pkg::out_item_t out_data
);

  `CCS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `CCS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data))
  `CCS_ASSERT(a_enable, clk, rst, out_valid |-> (out_data.charge_enable == (out_data.current_state != ccs_pkg::ST_ERROR)))
  `CCS_ASSERT(a_state_range, clk, rst, out_valid |-> (out_data.current_state <= ccs_pkg::ST_SHUTDOWN))
  `CCS_ASSERT(a_no_stall_free, clk, rst, !out_valid |-> !in_stall)

endmodule

bind charger_control_sequencer_core ccs_checker u_ccs_checker (.*);
